/* rtl/core/spa_pkg.sv */
// Shared types, constants and helpers for the sparse polynomial adder.
// No dependencies; used by spa_engine and sparse_polynomial_adder_unit.

package spa_pkg;

    // field widths
    localparam int COEF_W        = 32;
    localparam int EXP_W         = 10;
    localparam int CMD_W         = 2;
    localparam int MAX_TERMS_DEF = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TERM_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TERM_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    // one stored table entry
    typedef struct packed {
        logic [EXP_W-1:0]         exponent;
        logic signed [COEF_W-1:0] coefficient;
        logic                     clamped;
    } spa_entry_t;

    localparam int ENTRY_W = $bits(spa_entry_t);

    // one result beat handed to the output register
    typedef struct packed {
        logic signed [COEF_W-1:0] sum_coefficient;
        logic [EXP_W-1:0]         term_exponent;
        logic                     term_valid;
        logic                     last_term;
        logic                     sum_saturated;
        logic                     table_overflow;
    } spa_beat_t;

    // saturating add result
    typedef struct packed {
        logic signed [COEF_W-1:0] sum;
        logic                     clamped;
    } spa_sum_t;

    // signed add clamped to the coefficient range
    function automatic spa_sum_t sat_add(input logic signed [COEF_W-1:0] a,
                                         input logic signed [COEF_W-1:0] b);
        logic signed [COEF_W:0] wide;
        spa_sum_t               res;
        wide = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (wide[COEF_W] != wide[COEF_W-1]) begin
            res.clamped = 1'b1;
            if (wide[COEF_W]) begin
                res.sum = {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                res.sum = {1'b0, {(COEF_W-1){1'b1}}};
            end
        end else begin
            res.clamped = 1'b0;
            res.sum     = wide[COEF_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/core/spa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/spa_engine.sv */
// Sequencer for the sorted term table: binary search, merge or insert with
// shifting, and ascending emit. Depends on spa_pkg; drives an spa_ram instance.

module spa_engine #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int AW        = $clog2(MAX_TERMS),
    parameter int CW        = $clog2(MAX_TERMS + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [spa_pkg::CMD_W-1:0]        s_cmd,
    input  logic signed [spa_pkg::COEF_W-1:0] s_coefficient,
    input  logic [spa_pkg::EXP_W-1:0]        s_exponent,
    // result beats toward the output register
    input  logic                             out_free,
    output logic                             beat_valid,
    output spa_pkg::spa_beat_t               beat,
    // table memory
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [spa_pkg::ENTRY_W-1:0]      wr_data,
    output logic                             rd_en,
    output logic [AW-1:0]                    rd_addr,
    input  logic [spa_pkg::ENTRY_W-1:0]      rd_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SRCH_RD   = 4'd1;
    localparam logic [3:0] ST_SRCH_CMP  = 4'd2;
    localparam logic [3:0] ST_CHK_RD    = 4'd3;
    localparam logic [3:0] ST_CHK_CMP   = 4'd4;
    localparam logic [3:0] ST_SHF_RD    = 4'd5;
    localparam logic [3:0] ST_SHF_WR    = 4'd6;
    localparam logic [3:0] ST_EMIT_RD   = 4'd7;
    localparam logic [3:0] ST_EMIT_WAIT = 4'd8;

    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TERMS);
    localparam logic [CW-1:0] ONE        = CW'(1);

    logic [3:0]                        state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              dropped_reg, dropped_next;
    logic signed [spa_pkg::COEF_W-1:0] coef_reg, coef_next;
    logic [spa_pkg::EXP_W-1:0]         expo_reg, expo_next;
    logic [CW-1:0]                     lo_reg, lo_next;
    logic [CW-1:0]                     hi_reg, hi_next;
    logic [CW-1:0]                     mid_reg, mid_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic [CW-1:0]                     emit_n_reg, emit_n_next;
    logic [CW-1:0]                     emit_k_reg, emit_k_next;
    logic                              emit_ovf_reg, emit_ovf_next;

    spa_pkg::spa_entry_t rd_entry;
    spa_pkg::spa_entry_t new_entry;
    spa_pkg::spa_entry_t merged_entry;
    spa_pkg::spa_sum_t   merged;
    logic [CW:0]         mid_sum;
    logic                hit;
    logic                emit_last;

    assign rd_entry  = rd_data;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign merged    = spa_pkg::sat_add(rd_entry.coefficient, coef_reg);
    assign hit       = (lo_reg < count_reg) && (rd_entry.exponent == expo_reg);
    assign emit_last = (emit_k_reg + ONE) == emit_n_reg;

    always_comb begin
        new_entry.exponent    = expo_reg;
        new_entry.coefficient = coef_reg;
        new_entry.clamped     = 1'b0;
    end

    // stored entry with the new term added in
    always_comb begin
        merged_entry             = rd_entry;
        merged_entry.coefficient = merged.sum;
        merged_entry.clamped     = rd_entry.clamped | merged.clamped;
    end

    assign s_ready = (state_reg == ST_IDLE);

    // control sequencing
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        coef_next     = coef_reg;
        expo_next     = expo_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        idx_next      = idx_reg;
        emit_n_next   = emit_n_reg;
        emit_k_next   = emit_k_reg;
        emit_ovf_next = emit_ovf_reg;
        wr_en         = 1'b0;
        wr_addr       = lo_reg[AW-1:0];
        wr_data       = new_entry;
        rd_en         = 1'b0;
        rd_addr       = mid_reg[AW-1:0];
        beat_valid    = 1'b0;
        beat.sum_coefficient = rd_entry.coefficient;
        beat.term_exponent   = rd_entry.exponent;
        beat.term_valid      = 1'b1;
        beat.last_term       = emit_last;
        beat.sum_saturated   = rd_entry.clamped;
        beat.table_overflow  = emit_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    coef_next = s_coefficient;
                    expo_next = s_exponent;
                    if (s_cmd == spa_pkg::CMD_TERM_A || s_cmd == spa_pkg::CMD_TERM_B) begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = ST_SRCH_RD;
                    end else if (s_cmd == spa_pkg::CMD_FINISH) begin
                        // table and flag clear as the run starts
                        emit_n_next   = count_reg;
                        emit_k_next   = '0;
                        emit_ovf_next = dropped_reg;
                        count_next    = '0;
                        dropped_next  = 1'b0;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            // binary search for the first entry not below the new exponent
            ST_SRCH_RD: begin
                if (lo_reg == hi_reg) begin
                    state_next = ST_CHK_RD;
                end else begin
                    mid_next   = mid_sum[CW:1];
                    rd_en      = 1'b1;
                    rd_addr    = mid_next[AW-1:0];
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (rd_entry.exponent < expo_reg) begin
                    lo_next = mid_reg + ONE;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH_RD;
            end
            // fetch the entry at the insertion point
            ST_CHK_RD: begin
                rd_en      = (lo_reg < count_reg);
                rd_addr    = lo_reg[AW-1:0];
                state_next = ST_CHK_CMP;
            end
            ST_CHK_CMP: begin
                if (hit) begin
                    wr_en      = 1'b1;
                    wr_data    = merged_entry;
                    state_next = ST_IDLE;
                end else if (count_reg == FULL_COUNT) begin
                    dropped_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    idx_next   = count_reg;
                    state_next = ST_SHF_RD;
                end
            end
            // move entries up one slot from the top down to the insertion point
            ST_SHF_RD: begin
                if (idx_reg == lo_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg[AW-1:0];
                    wr_data    = new_entry;
                    count_next = count_reg + ONE;
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_next[AW-1:0] - AW'(1);
                    state_next = ST_SHF_WR;
                end
            end
            ST_SHF_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_entry;
                idx_next   = idx_reg - ONE;
                state_next = ST_SHF_RD;
            end
            // emit one stored term per read
            ST_EMIT_RD: begin
                if (out_free) begin
                    if (emit_n_reg == '0) begin
                        beat_valid           = 1'b1;
                        beat.sum_coefficient = '0;
                        beat.term_exponent   = '0;
                        beat.term_valid      = 1'b0;
                        beat.last_term       = 1'b1;
                        beat.sum_saturated   = 1'b0;
                        state_next           = ST_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = emit_k_reg[AW-1:0];
                        state_next = ST_EMIT_WAIT;
                    end
                end
            end
            ST_EMIT_WAIT: begin
                beat_valid  = 1'b1;
                emit_k_next = emit_k_reg + ONE;
                state_next  = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        coef_reg     <= coef_next;
        expo_reg     <= expo_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        idx_reg      <= idx_next;
        emit_n_reg   <= emit_n_next;
        emit_k_reg   <= emit_k_next;
        emit_ovf_reg <= emit_ovf_next;
    end

endmodule

/* rtl/core/sparse_polynomial_adder_unit.sv */
// Top level of the sparse polynomial adder: table memory, sequencer and
// result register. Depends on spa_pkg, spa_ram and spa_engine.

// Terms of two polynomials are loaded one beat at a time (cmd 0 or 1) into a
// table kept sorted by exponent in a single-port-write, registered-read RAM of
// MAX_TERMS entries; a term with a stored exponent adds into that entry with
// 32-bit saturation, otherwise it is inserted, or dropped with a sticky
// overflow flag when the table is full. A finish beat (cmd 2) emits every
// stored term in ascending exponent order with the last one marked, then the
// table starts empty; an empty table yields one beat with term_valid low.
// One item is worked at a time and s_ready is high only between items. After
// its beat is taken, a term keeps s_ready low through a binary search for its
// exponent and a check of the entry at the insertion point, and when it is
// inserted, through the move of each entry above the insertion point; each
// search step and each entry moved is one RAM read followed by one compare or
// write. A finish reads each stored term from the RAM and loads it into the
// output register, and waits while the output register is held by m_ready.

module sparse_polynomial_adder_unit #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [spa_pkg::CMD_W-1:0]         s_cmd,
    input  logic signed [spa_pkg::COEF_W-1:0] s_coefficient,
    input  logic [spa_pkg::EXP_W-1:0]         s_exponent,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [spa_pkg::COEF_W-1:0] m_sum_coefficient,
    output logic [spa_pkg::EXP_W-1:0]         m_term_exponent,
    output logic                              m_term_valid,
    output logic                              m_last_term,
    output logic                              m_sum_saturated,
    output logic                              m_table_overflow
);

    localparam int AW = $clog2(MAX_TERMS);

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [spa_pkg::ENTRY_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [spa_pkg::ENTRY_W-1:0] rd_data;
    logic                        out_free;
    logic                        beat_valid;
    spa_pkg::spa_beat_t          beat;
    logic                        m_valid_reg, m_valid_next;
    spa_pkg::spa_beat_t          m_beat_reg;

    // sorted term table
    spa_ram #(
        .WIDTH (spa_pkg::ENTRY_W),
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spa_engine #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_coefficient (s_coefficient),
        .s_exponent    (s_exponent),
        .out_free      (out_free),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // output register, free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (beat_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_valid) begin
            m_beat_reg <= beat;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sum_coefficient = m_beat_reg.sum_coefficient;
    assign m_term_exponent   = m_beat_reg.term_exponent;
    assign m_term_valid      = m_beat_reg.term_valid;
    assign m_last_term       = m_beat_reg.last_term;
    assign m_sum_saturated   = m_beat_reg.sum_saturated;
    assign m_table_overflow  = m_beat_reg.table_overflow;

endmodule

/* dv/sparse_polynomial_adder_unit_test.sv */
// Self-checking testbench for sparse_polynomial_adder_unit: merges, saturation,
// table overflow, empty finishes, random term sequences and output backpressure.
// Depends on spa_pkg and the sparse_polynomial_adder_unit RTL only.
`timescale 1ns / 1ps

module sparse_polynomial_adder_unit_test;

    import spa_pkg::*;

    localparam int          MAX_TERMS     = MAX_TERMS_DEF;
    localparam int unsigned RANDOM_ITEMS  = 30;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam longint      COEF_MAX      = 64'sd2147483647;
    localparam longint      COEF_MIN      = -64'sd2147483648;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd         = '0;
    logic signed [COEF_W-1:0] s_coefficient = '0;
    logic [EXP_W-1:0]         s_exponent    = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [COEF_W-1:0] m_sum_coefficient;
    logic [EXP_W-1:0]         m_term_exponent;
    logic                     m_term_valid;
    logic                     m_last_term;
    logic                     m_sum_saturated;
    logic                     m_table_overflow;

    // predicted term table
    logic [EXP_W-1:0]         tbl_exp   [MAX_TERMS];
    logic signed [COEF_W-1:0] tbl_coef  [MAX_TERMS];
    logic                     tbl_clamp [MAX_TERMS];
    int unsigned              tbl_count   = 0;
    logic                     tbl_dropped = 1'b0;

    spa_beat_t   expected_terms[$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    bit          stalls_on   = 1'b1;

    // receiver idling and long hold-off
    int unsigned rx_wait   = 0;
    int unsigned rx_draw;
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    sparse_polynomial_adder_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_coefficient     (s_coefficient),
        .s_exponent        (s_exponent),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sum_coefficient (m_sum_coefficient),
        .m_term_exponent   (m_term_exponent),
        .m_term_valid      (m_term_valid),
        .m_last_term       (m_last_term),
        .m_sum_saturated   (m_sum_saturated),
        .m_table_overflow  (m_table_overflow)
    );

    always #1 aclk = ~aclk;

    // add a term into the sorted table, insert it, or drop it when full
    function automatic void merge_term(input logic signed [COEF_W-1:0] coef,
                                       input logic [EXP_W-1:0] expo);
        int unsigned pos;
        longint      total;
        pos = 0;
        while (pos < tbl_count && tbl_exp[pos] < expo) pos++;
        if (pos < tbl_count && tbl_exp[pos] == expo) begin
            total = longint'(tbl_coef[pos]) + longint'(coef);
            if (total > COEF_MAX) begin
                total = COEF_MAX;
                tbl_clamp[pos] = 1'b1;
            end else if (total < COEF_MIN) begin
                total = COEF_MIN;
                tbl_clamp[pos] = 1'b1;
            end
            tbl_coef[pos] = total[COEF_W-1:0];
            return;
        end
        if (tbl_count >= MAX_TERMS) begin
            tbl_dropped = 1'b1;
            return;
        end
        for (int unsigned k = tbl_count; k > pos; k--) begin
            tbl_exp[k]   = tbl_exp[k-1];
            tbl_coef[k]  = tbl_coef[k-1];
            tbl_clamp[k] = tbl_clamp[k-1];
        end
        tbl_exp[pos]   = expo;
        tbl_coef[pos]  = coef;
        tbl_clamp[pos] = 1'b0;
        tbl_count++;
    endfunction

    // queue the beats of a finish and empty the table
    function automatic void emit_table();
        spa_beat_t b;
        if (tbl_count == 0) begin
            b = '0;
            b.last_term      = 1'b1;
            b.table_overflow = tbl_dropped;
            expected_terms.push_back(b);
        end
        for (int unsigned k = 0; k < tbl_count; k++) begin
            b.sum_coefficient = tbl_coef[k];
            b.term_exponent   = tbl_exp[k];
            b.term_valid      = 1'b1;
            b.last_term       = (k + 1 == tbl_count);
            b.sum_saturated   = tbl_clamp[k];
            b.table_overflow  = tbl_dropped;
            expected_terms.push_back(b);
        end
        tbl_count   = 0;
        tbl_dropped = 1'b0;
    endfunction

    function automatic void apply_item(input logic [CMD_W-1:0] cmd,
                                       input logic signed [COEF_W-1:0] coef,
                                       input logic [EXP_W-1:0] expo);
        case (cmd)
            CMD_TERM_A, CMD_TERM_B: begin
                merge_term(coef, expo);
            end
            CMD_FINISH: begin
                emit_table();
            end
            default: begin
            end
        endcase
    endfunction

    // drive one beat, wait for acceptance, then update the prediction
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic signed [COEF_W-1:0] coef,
                             input logic [EXP_W-1:0] expo);
        int unsigned gap;
        gap = stalls_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_coefficient <= coef;
        s_exponent    <= expo;
        do @(posedge aclk); while (!s_ready);
        apply_item(cmd, coef, expo);
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coefficient();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 200)) - 100;
            1: return COEF_MAX[COEF_W-1:0] - $urandom_range(0, 1000);
            2: return COEF_MIN[COEF_W-1:0] + $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // extremes, saturation both ways, zero sums, ordering, unused command
    task automatic test_directed();
        stalls_on = 1'b1;
        send_item(CMD_FINISH, 32'sd0, 10'd0);
        send_item(CMD_TERM_A, COEF_MAX[COEF_W-1:0], 10'd0);
        send_item(CMD_TERM_B, 32'sd1, 10'd0);
        send_item(CMD_TERM_A, -32'sd1, 10'd0);
        send_item(CMD_TERM_A, COEF_MIN[COEF_W-1:0], 10'd1023);
        send_item(CMD_TERM_B, COEF_MIN[COEF_W-1:0], 10'd1023);
        send_item(CMD_TERM_A, 32'sd5, 10'd512);
        send_item(CMD_TERM_B, -32'sd5, 10'd512);
        send_item(CMD_TERM_A, 32'h5555_5555, 10'h155);
        send_item(CMD_TERM_B, 32'hAAAA_AAAA, 10'h2AA);
        send_item(CMD_TERM_A, 32'sd7, 10'd600);
        send_item(CMD_TERM_B, 32'sd3, 10'd300);
        send_item(CMD_TERM_A, 32'sd1, 10'd900);
        send_item(CMD_UNUSED, 32'sd12345, 10'd300);
        send_item(CMD_FINISH, 32'hFFFF_FFFF, 10'h3FF);
        send_item(CMD_UNUSED, 32'sd99, 10'd7);
        send_item(CMD_FINISH, 32'sd0, 10'd0);
    endtask

    // fill the table, merge while full, drop new exponents, then clear
    task automatic test_table_overflow();
        int unsigned pool[1024];
        int unsigned j;
        int unsigned swap;
        for (int unsigned i = 0; i < 1024; i++) pool[i] = i;
        for (int unsigned i = 1023; i > 0; i--) begin
            j       = $urandom_range(0, i);
            swap    = pool[i];
            pool[i] = pool[j];
            pool[j] = swap;
        end
        stalls_on = 1'b0;
        for (int unsigned i = 0; i < MAX_TERMS; i++) begin
            send_item(CMD_W'($urandom_range(0, 1)), rand_coefficient(), EXP_W'(pool[i]));
        end
        stalls_on = 1'b1;
        send_item(CMD_TERM_B, rand_coefficient(), EXP_W'(pool[0]));
        for (int unsigned i = 0; i < 3; i++) begin
            send_item(CMD_W'($urandom_range(0, 1)), rand_coefficient(),
                      EXP_W'(pool[MAX_TERMS + i]));
        end
        send_item(CMD_TERM_A, rand_coefficient(), EXP_W'(pool[MAX_TERMS - 1]));
        send_item(CMD_FINISH, $urandom, EXP_W'($urandom));
        send_item(CMD_FINISH, $urandom, EXP_W'($urandom));
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        stalls_on = 1'b0;
        for (int unsigned i = 0; i < 30; i++) begin
            send_item(CMD_W'($urandom_range(0, 1)), rand_coefficient(),
                      EXP_W'($urandom_range(0, 63)));
        end
        hold_req <= hold_req + 1;
        send_item(CMD_FINISH, $urandom, EXP_W'($urandom));
        for (int unsigned i = 0; i < 10; i++) begin
            send_item(CMD_W'($urandom_range(0, 1)), rand_coefficient(),
                      EXP_W'($urandom_range(0, 1023)));
        end
        send_item(CMD_FINISH, $urandom, EXP_W'($urandom));
    endtask

    // well-formed load-and-finish runs with some noise and stray finishes
    task automatic test_random_sequences();
        int unsigned sent;
        int unsigned n;
        int unsigned base;
        bit          narrow;
        logic [EXP_W-1:0] expo;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            stalls_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0: n = 0;
                1: n = $urandom_range(40, 80);
                default: n = $urandom_range(1, 12);
            endcase
            narrow = $urandom_range(0, 1);
            base   = $urandom_range(0, 1023 - 15);
            for (int unsigned i = 0; i < n; i++) begin
                expo = narrow ? EXP_W'(base + $urandom_range(0, 15))
                              : EXP_W'($urandom_range(0, 1023));
                case ($urandom_range(0, 19))
                    0: begin
                        send_item(CMD_UNUSED, $urandom, EXP_W'($urandom));
                    end
                    1: begin
                        send_item(CMD_FINISH, $urandom, EXP_W'($urandom));
                        sent++;
                    end
                    default: begin
                        send_item(CMD_W'($urandom_range(0, 1)), rand_coefficient(), expo);
                        sent++;
                    end
                endcase
            end
            send_item(CMD_FINISH, $urandom, EXP_W'($urandom));
            sent++;
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_terms.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver ready with random stalls per beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
        end else if (m_ready) begin
            if (m_valid) begin
                rx_draw = stalls_on ? $urandom_range(0, 10) : 0;
                if (rx_draw != 0) begin
                    m_ready <= 1'b0;
                    rx_wait <= rx_draw;
                end
            end
        end else if (rx_wait <= 1) begin
            m_ready <= 1'b1;
            rx_wait <= 0;
        end else begin
            rx_wait <= rx_wait - 1;
        end
    end

    // long hold-off counter
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // compare every accepted result beat with the oldest expectation
    always @(posedge aclk) begin
        spa_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_terms.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual exponent %0d coef %0d",
                         $time, m_term_exponent, m_sum_coefficient);
                fail_count++;
            end else begin
                want = expected_terms.pop_front();
                compare_field("sum_coefficient", want.sum_coefficient, m_sum_coefficient);
                compare_field("term_exponent", want.term_exponent, m_term_exponent);
                compare_field("term_valid", want.term_valid, m_term_valid);
                compare_field("last_term", want.last_term, m_last_term);
                compare_field("sum_saturated", want.sum_saturated, m_sum_saturated);
                compare_field("table_overflow", want.table_overflow, m_table_overflow);
            end
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_overflow();
        test_backpressure();
        test_random_sequences();
        wait_for_results();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
